@@ rtl/baw_pkg.sv @@
`default_nettype none

package baw_pkg;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOC_INV_SQ = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VAL_INV_SQ = 2'd1;

   localparam int unsigned REG_BITS = 24;
   localparam logic [REG_BITS-1:0] LOC_INV_SQ_RESET = 24'd10486;
   localparam logic [REG_BITS-1:0] VAL_INV_SQ_RESET = 24'd41943;

   localparam int unsigned VALUE_BITS  = 8;
   localparam int unsigned WEIGHT_BITS = 17;

   // exponent split: t is Q.24, k = t[27:20], residue = t[19:0] << 6 in Q.30
   localparam int unsigned K_BITS     = 8;
   localparam int unsigned K_LSB      = 20;
   localparam int unsigned T_OVER_LSB = K_LSB + K_BITS;
   localparam int unsigned R_BITS     = 26;
   localparam int unsigned R_PAD      = R_BITS - K_LSB;

   // widths of the polynomial terms (r < 2^26)
   localparam int unsigned R2_BITS = 22;
   localparam int unsigned R3_BITS = 18;
   localparam int unsigned R4_BITS = 14;
   localparam int unsigned Q3_BITS = 16;
   localparam int unsigned Q4_BITS = 10;

   localparam int unsigned Q30_BITS = 31;
   localparam int unsigned Q30_FRAC = 30;
   localparam int unsigned PROD_BITS = 2 * Q30_BITS;
   localparam int unsigned OUT_SHIFT = 14;

   // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2^17
   localparam logic [16:0] DIV3_MUL   = 17'd43691;
   localparam int unsigned DIV3_SHIFT = 17;

   typedef struct packed {
      logic                over;
      logic [K_BITS-1:0]   k;
      logic [R_BITS-1:0]   r;
   } exp_arg_type;

   typedef logic [Q30_BITS-1:0] pow_table_type [2**K_BITS];

   // degree-4 Taylor polynomial of exp(-r), Q.30, evaluated at elaboration
   function automatic longint unsigned exp_small_const(longint unsigned r);
      longint unsigned r2;
      longint unsigned r3;
      longint unsigned r4;
      r2 = (r * r) >> 30;
      r3 = (r2 * r) >> 30;
      r4 = (r3 * r) >> 30;
      return ((64'd1 << 30) + r2 / 2 + r4 / 24) - (r + r3 / 6);
   endfunction

   // S^k by square-and-multiply from the lowest bit, S = P(1/16)
   function automatic pow_table_type build_pow_table();
      pow_table_type   tbl;
      longint unsigned step;
      longint unsigned acc;
      for (int k = 0; k < 2**K_BITS; k++) begin
         acc  = 64'd1 << 30;
         step = exp_small_const(64'd1 << 26);
         for (int i = 0; i < K_BITS; i++) begin
            if (((k >> i) & 1) != 0) begin
               acc = (acc * step + (64'd1 << 29)) >> 30;
            end
            step = (step * step + (64'd1 << 29)) >> 30;
         end
         tbl[k] = acc[Q30_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam pow_table_type POW_TABLE = build_pow_table();

endpackage

`default_nettype wire

@@ rtl/baw_exp_unit.sv @@
`default_nettype none

// exp(-t) for a split exponent, eight register stages, Q1.16 result
module baw_exp_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_stall,
   input  wire baw_pkg::exp_arg_type          in_arg,
   output      logic                          out_valid,
   input  wire logic                          out_stall,
   output      logic [baw_pkg::WEIGHT_BITS-1:0] out_weight
);
   import baw_pkg::*;

   localparam int unsigned STAGES = 8;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   // stage 0: r^2, table lookup of S^k
   logic [R2_BITS-1:0]   r2_e0_ff, r2_e0_in;
   logic [R_BITS-1:0]    r_e0_ff;
   logic [Q30_BITS-1:0]  pow_e0_ff;
   logic                 over_e0_ff;
   logic [2*R_BITS-1:0]  rr_prod;
   // stage 1: r^3
   logic [R3_BITS-1:0]   r3_e1_ff, r3_e1_in;
   logic [R2_BITS-1:0]   r2_e1_ff;
   logic [R_BITS-1:0]    r_e1_ff;
   logic [Q30_BITS-1:0]  pow_e1_ff;
   logic                 over_e1_ff;
   logic [R2_BITS+R_BITS-1:0] r3_prod;
   // stage 2: r^4 and r^3/6
   logic [R4_BITS-1:0]   r4_e2_ff, r4_e2_in;
   logic [Q3_BITS-1:0]   q3_e2_ff, q3_e2_in;
   logic [R2_BITS-1:0]   r2_e2_ff;
   logic [R_BITS-1:0]    r_e2_ff;
   logic [Q30_BITS-1:0]  pow_e2_ff;
   logic                 over_e2_ff;
   logic [R3_BITS+R_BITS-1:0] r4_prod;
   logic [R3_BITS-1+DIV3_SHIFT-1:0] q3_prod;
   // stage 3: r^4/24 and the partial sum
   logic [Q4_BITS-1:0]   q4_e3_ff, q4_e3_in;
   logic [Q30_BITS-1:0]  part_e3_ff, part_e3_in;
   logic [Q30_BITS-1:0]  pow_e3_ff;
   logic                 over_e3_ff;
   logic [R4_BITS-3+DIV3_SHIFT-1:0] q4_prod;
   // stage 4: polynomial value
   logic [Q30_BITS-1:0]  poly_e4_ff, poly_e4_in;
   logic [Q30_BITS-1:0]  pow_e4_ff;
   logic                 over_e4_ff;
   // stage 5: S^k * P(r)
   logic [PROD_BITS-1:0] prod_e5_ff, prod_e5_in;
   logic                 over_e5_ff;
   // stage 6: Q.30 rounding
   logic [Q30_BITS-1:0]  acc_e6_ff, acc_e6_in;
   logic [PROD_BITS-1:0] prod_rnd;
   logic                 over_e6_ff;
   // stage 7: output register
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [Q30_BITS-1:0]    acc_rnd;

   // advance chain: a stage moves when empty or when the next one moves
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || !out_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in = {vld_ff[STAGES-2:0], in_valid};
   end

   assign in_stall  = !adv[0];
   assign out_valid = vld_ff[STAGES-1];
   assign out_weight = weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // datapath arithmetic
   always_comb begin
      rr_prod    = (2*R_BITS)'(in_arg.r) * (2*R_BITS)'(in_arg.r);
      r2_e0_in   = rr_prod[2*R_BITS-1:Q30_FRAC];
      r3_prod    = (R2_BITS+R_BITS)'(r2_e0_ff) * (R2_BITS+R_BITS)'(r_e0_ff);
      r3_e1_in   = r3_prod[R2_BITS+R_BITS-1:Q30_FRAC];
      r4_prod    = (R3_BITS+R_BITS)'(r3_e1_ff) * (R3_BITS+R_BITS)'(r_e1_ff);
      r4_e2_in   = r4_prod[R3_BITS+R_BITS-1:Q30_FRAC];
      q3_prod    = (R3_BITS-1+DIV3_SHIFT)'(r3_e1_ff[R3_BITS-1:1])
                   * (R3_BITS-1+DIV3_SHIFT)'(DIV3_MUL);
      q3_e2_in   = q3_prod[R3_BITS-1+DIV3_SHIFT-2:DIV3_SHIFT];
      q4_prod    = (R4_BITS-3+DIV3_SHIFT)'(r4_e2_ff[R4_BITS-1:3])
                   * (R4_BITS-3+DIV3_SHIFT)'(DIV3_MUL);
      q4_e3_in   = q4_prod[R4_BITS-3+DIV3_SHIFT-2:DIV3_SHIFT];
      part_e3_in = (Q30_BITS'(1) << Q30_FRAC)
                   + Q30_BITS'(r2_e2_ff[R2_BITS-1:1])
                   - Q30_BITS'(r_e2_ff)
                   - Q30_BITS'(q3_e2_ff);
      poly_e4_in = part_e3_ff + Q30_BITS'(q4_e3_ff);
      prod_e5_in = PROD_BITS'(pow_e4_ff) * PROD_BITS'(poly_e4_ff);
      prod_rnd   = prod_e5_ff + (PROD_BITS'(1) << (Q30_FRAC - 1));
      acc_e6_in  = prod_rnd[Q30_FRAC+Q30_BITS-1:Q30_FRAC];
      acc_rnd    = acc_e6_ff + (Q30_BITS'(1) << (OUT_SHIFT - 1));
      weight_in  = over_e6_ff ? '0 : acc_rnd[OUT_SHIFT+WEIGHT_BITS-1:OUT_SHIFT];
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         r2_e0_ff   <= r2_e0_in;
         r_e0_ff    <= in_arg.r;
         pow_e0_ff  <= POW_TABLE[in_arg.k];
         over_e0_ff <= in_arg.over;
      end
      if (adv[1]) begin
         r3_e1_ff   <= r3_e1_in;
         r2_e1_ff   <= r2_e0_ff;
         r_e1_ff    <= r_e0_ff;
         pow_e1_ff  <= pow_e0_ff;
         over_e1_ff <= over_e0_ff;
      end
      if (adv[2]) begin
         r4_e2_ff   <= r4_e2_in;
         q3_e2_ff   <= q3_e2_in;
         r2_e2_ff   <= r2_e1_ff;
         r_e2_ff    <= r_e1_ff;
         pow_e2_ff  <= pow_e1_ff;
         over_e2_ff <= over_e1_ff;
      end
      if (adv[3]) begin
         q4_e3_ff   <= q4_e3_in;
         part_e3_ff <= part_e3_in;
         pow_e3_ff  <= pow_e2_ff;
         over_e3_ff <= over_e2_ff;
      end
      if (adv[4]) begin
         poly_e4_ff <= poly_e4_in;
         pow_e4_ff  <= pow_e3_ff;
         over_e4_ff <= over_e3_ff;
      end
      if (adv[5]) begin
         prod_e5_ff <= prod_e5_in;
         over_e5_ff <= over_e4_ff;
      end
      if (adv[6]) begin
         acc_e6_ff  <= acc_e6_in;
         over_e6_ff <= over_e5_ff;
      end
      if (adv[7]) begin
         weight_ff  <= weight_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bilateral_affinity_weight.sv @@
`default_nettype none

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  ref_x, ref_y, ref_value, cand_x, cand_y, cand_value
// rsp      out        rsp_valid/rsp_stall  weight (Q1.16)
// csr      in         csr_write            csr_index, csr_data (no read-back)
//
// One transaction per cycle sustained while rsp_stall is low; five stages forming
// the exponent, followed by eight in the exponential unit.
// Each stage holds its valid bit and advances when empty or when the stage after
// it advances, so bubbles collapse and a stall loses nothing.
// Synchronous reset clears the valid bits and loads the default bandwidths.
module bilateral_affinity_weight #(
   parameter int unsigned COORD_BITS = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [COORD_BITS-1:0]             req_ref_x,
   input  wire logic [COORD_BITS-1:0]             req_ref_y,
   input  wire logic [baw_pkg::VALUE_BITS-1:0]    req_ref_value,
   input  wire logic [COORD_BITS-1:0]             req_cand_x,
   input  wire logic [COORD_BITS-1:0]             req_cand_y,
   input  wire logic [baw_pkg::VALUE_BITS-1:0]    req_cand_value,
   // response
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [baw_pkg::WEIGHT_BITS-1:0]   rsp_weight,
   // configuration
   input  wire logic                              csr_write,
   input  wire logic [baw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [baw_pkg::REG_BITS-1:0]      csr_data
);
   import baw_pkg::*;

   localparam int unsigned STAGES     = 5;
   localparam int unsigned SQ_BITS    = 2 * COORD_BITS;
   localparam int unsigned VSQ_BITS   = 2 * VALUE_BITS;
   localparam int unsigned LSUM_BITS  = SQ_BITS + 1;
   localparam int unsigned LTERM_BITS = LSUM_BITS + REG_BITS;
   localparam int unsigned VTERM_BITS = VSQ_BITS + REG_BITS;
   localparam int unsigned T_BITS     =
      ((LTERM_BITS > VTERM_BITS) ? LTERM_BITS : VTERM_BITS) + 1;

   logic [REG_BITS-1:0] loc_inv_sq_ff;
   logic [REG_BITS-1:0] val_inv_sq_ff;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;
   logic              exp_stall;

   logic [COORD_BITS-1:0] dx_ff, dx_in;
   logic [COORD_BITS-1:0] dy_ff, dy_in;
   logic [VALUE_BITS-1:0] dv_ff, dv_in;
   logic [SQ_BITS-1:0]    dx2_ff, dx2_in;
   logic [SQ_BITS-1:0]    dy2_ff, dy2_in;
   logic [VSQ_BITS-1:0]   dv2_ff, dv2_in;
   logic [LSUM_BITS-1:0]  lsum_ff, lsum_in;
   logic [VSQ_BITS-1:0]   dv2_s3_ff;
   logic [LTERM_BITS-1:0] lterm_ff, lterm_in;
   logic [VTERM_BITS-1:0] vterm_ff, vterm_in;
   logic [T_BITS-1:0]     t_sum;
   exp_arg_type           arg_ff, arg_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         loc_inv_sq_ff <= LOC_INV_SQ_RESET;
         val_inv_sq_ff <= VAL_INV_SQ_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOC_INV_SQ: loc_inv_sq_ff <= csr_data;
            CSR_VAL_INV_SQ: val_inv_sq_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // advance chain
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || !exp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in = {vld_ff[STAGES-2:0], req_valid};
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // exponent datapath: differences, squares, sum, scaling, split
   always_comb begin
      dx_in    = (req_ref_x >= req_cand_x) ? req_ref_x - req_cand_x
                                           : req_cand_x - req_ref_x;
      dy_in    = (req_ref_y >= req_cand_y) ? req_ref_y - req_cand_y
                                           : req_cand_y - req_ref_y;
      dv_in    = (req_ref_value >= req_cand_value) ? req_ref_value - req_cand_value
                                                   : req_cand_value - req_ref_value;
      dx2_in   = SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
      dy2_in   = SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
      dv2_in   = VSQ_BITS'(dv_ff) * VSQ_BITS'(dv_ff);
      lsum_in  = LSUM_BITS'(dx2_ff) + LSUM_BITS'(dy2_ff);
      lterm_in = LTERM_BITS'(lsum_ff) * LTERM_BITS'(loc_inv_sq_ff);
      vterm_in = VTERM_BITS'(dv2_s3_ff) * VTERM_BITS'(val_inv_sq_ff);
      t_sum    = T_BITS'(lterm_ff) + T_BITS'(vterm_ff);
      arg_in.over = |t_sum[T_BITS-1:T_OVER_LSB];
      arg_in.k    = t_sum[T_OVER_LSB-1:K_LSB];
      arg_in.r    = {t_sum[K_LSB-1:0], {R_PAD{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dv_ff <= dv_in;
      end
      if (adv[1]) begin
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
         dv2_ff <= dv2_in;
      end
      if (adv[2]) begin
         lsum_ff   <= lsum_in;
         dv2_s3_ff <= dv2_ff;
      end
      if (adv[3]) begin
         lterm_ff <= lterm_in;
         vterm_ff <= vterm_in;
      end
      if (adv[4]) begin
         arg_ff <= arg_in;
      end
   end

   // exponential and output register
   baw_exp_unit u_exp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld_ff[STAGES-1]),
      .in_stall   (exp_stall),
      .in_arg     (arg_ff),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_weight (rsp_weight)
   );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import baw_pkg::*;

   localparam int unsigned COORD_BITS   = 12;
   localparam int unsigned COORD_TOP    = (1 << COORD_BITS) - 1;
   localparam int unsigned VALUE_TOP    = (1 << VALUE_BITS) - 1;
   localparam int unsigned RANDOM_PAIRS = 400;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned DRAIN_SLACK  = 20;
   localparam int unsigned CHOKE_CYCLES = 250;

   // indexes that map to no register
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   localparam longint unsigned Q30_UNIT   = 64'd1 << 30;
   localparam longint unsigned EXPO_LIMIT = 64'd16 << 24;

   typedef struct packed {
      logic [COORD_BITS-1:0] ref_x;
      logic [COORD_BITS-1:0] ref_y;
      logic [VALUE_BITS-1:0] ref_value;
      logic [COORD_BITS-1:0] cand_x;
      logic [COORD_BITS-1:0] cand_y;
      logic [VALUE_BITS-1:0] cand_value;
   } pixel_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [COORD_BITS-1:0]  req_ref_x      = '0;
   logic [COORD_BITS-1:0]  req_ref_y      = '0;
   logic [VALUE_BITS-1:0]  req_ref_value  = '0;
   logic [COORD_BITS-1:0]  req_cand_x     = '0;
   logic [COORD_BITS-1:0]  req_cand_y     = '0;
   logic [VALUE_BITS-1:0]  req_cand_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [WEIGHT_BITS-1:0] rsp_weight;
   logic                   csr_write      = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [REG_BITS-1:0]    csr_data       = '0;

   // predictor copy of the bandwidth registers
   logic [REG_BITS-1:0] loc_bw = LOC_INV_SQ_RESET;
   logic [REG_BITS-1:0] val_bw = VAL_INV_SQ_RESET;

   pixel_pair_type         pending_pairs[$];
   logic [WEIGHT_BITS-1:0] weights_due[$];
   pixel_pair_type         offered;

   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   int unsigned pairs_accepted = 0;
   int unsigned weights_checked = 0;
   int unsigned unity_count = 0;
   int unsigned zero_count  = 0;
   int unsigned mismatch_count = 0;
   int unsigned csr_writes = 0;

   logic        choke_start = 1'b0;
   int unsigned choke_left  = 0;
   int unsigned chokes_done = 0;
   int unsigned stall_mode  = 0;
   int unsigned mode_left   = 0;
   int unsigned beat        = 0;

   bilateral_affinity_weight #(.COORD_BITS(COORD_BITS)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ref_x      (req_ref_x),
      .req_ref_y      (req_ref_y),
      .req_ref_value  (req_ref_value),
      .req_cand_x     (req_cand_x),
      .req_cand_y     (req_cand_y),
      .req_cand_value (req_cand_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_weight     (rsp_weight),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #1 clock = ~clock;

   // Q.30 product, rounded
   function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   // exp(-r) by degree-4 Taylor series, r in Q.30 up to 1/16
   function automatic longint unsigned exp_neg_poly(longint unsigned r);
      longint unsigned r2;
      longint unsigned r3;
      longint unsigned r4;
      r2 = (r * r) >> 30;
      r3 = (r2 * r) >> 30;
      r4 = (r3 * r) >> 30;
      return (Q30_UNIT + r2 / 2 + r4 / 24) - (r + r3 / 6);
   endfunction

   // bilateral weight of one pixel pair under the given bandwidths
   function automatic logic [WEIGHT_BITS-1:0] predict_weight(pixel_pair_type p,
                                                            logic [REG_BITS-1:0] loc,
                                                            logic [REG_BITS-1:0] val);
      longint unsigned dx;
      longint unsigned dy;
      longint unsigned dv;
      longint unsigned expo;
      longint unsigned ratio;
      longint unsigned acc;
      logic [K_BITS-1:0] k;
      dx = (p.ref_x >= p.cand_x) ? 64'(p.ref_x - p.cand_x) : 64'(p.cand_x - p.ref_x);
      dy = (p.ref_y >= p.cand_y) ? 64'(p.ref_y - p.cand_y) : 64'(p.cand_y - p.ref_y);
      dv = (p.ref_value >= p.cand_value) ? 64'(p.ref_value - p.cand_value)
                                         : 64'(p.cand_value - p.ref_value);
      expo = (dx * dx + dy * dy) * 64'(loc) + dv * dv * 64'(val);
      if (expo >= EXPO_LIMIT) return '0;
      k = K_BITS'(expo >> 20);
      // e^-(k/16) by square-and-multiply, then the residue
      ratio = exp_neg_poly(64'd1 << 26);
      acc = Q30_UNIT;
      for (int i = 0; i < K_BITS; i++) begin
         if (k[i]) acc = fix_mul(acc, ratio);
         ratio = fix_mul(ratio, ratio);
      end
      acc = fix_mul(acc, exp_neg_poly((expo & 64'hFFFFF) << 6));
      return WEIGHT_BITS'((acc + 64'd8192) >> 14);
   endfunction

   function automatic int unsigned nudge(int unsigned base, int unsigned span,
                                         int unsigned top);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - int'(span);
      if (v < 0) v = 0;
      if (v > int'(top)) v = int'(top);
      return v;
   endfunction

   function automatic int unsigned pick_extreme(int unsigned top);
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   // mostly nearby pairs so that weights are not all zero
   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      int unsigned span;
      int unsigned vspan;
      p.ref_x     = COORD_BITS'($urandom_range(0, COORD_TOP));
      p.ref_y     = COORD_BITS'($urandom_range(0, COORD_TOP));
      p.ref_value = VALUE_BITS'($urandom_range(0, VALUE_TOP));
      case ($urandom_range(0, 3))
         0:       span = 1;
         1:       span = 4;
         2:       span = 12;
         default: span = 40;
      endcase
      vspan = $urandom_range(0, 1) ? span : $urandom_range(0, 90);
      case ($urandom_range(0, 9))
         6: begin
            p.cand_x     = COORD_BITS'($urandom_range(0, COORD_TOP));
            p.cand_y     = COORD_BITS'($urandom_range(0, COORD_TOP));
            p.cand_value = VALUE_BITS'($urandom_range(0, VALUE_TOP));
         end
         7: begin
            p.cand_x     = p.ref_x;
            p.cand_y     = p.ref_y;
            p.cand_value = p.ref_value;
         end
         8: begin
            p.ref_x      = COORD_BITS'(pick_extreme(COORD_TOP));
            p.ref_y      = COORD_BITS'(pick_extreme(COORD_TOP));
            p.ref_value  = VALUE_BITS'(pick_extreme(VALUE_TOP));
            p.cand_x     = COORD_BITS'(pick_extreme(COORD_TOP));
            p.cand_y     = COORD_BITS'(pick_extreme(COORD_TOP));
            p.cand_value = VALUE_BITS'(pick_extreme(VALUE_TOP));
         end
         9: begin
            p.cand_x     = COORD_BITS'(nudge(p.ref_x, 200, COORD_TOP));
            p.cand_y     = COORD_BITS'(nudge(p.ref_y, 200, COORD_TOP));
            p.cand_value = VALUE_BITS'(nudge(p.ref_value, 120, VALUE_TOP));
         end
         default: begin
            p.cand_x     = COORD_BITS'(nudge(p.ref_x, span, COORD_TOP));
            p.cand_y     = COORD_BITS'(nudge(p.ref_y, span, COORD_TOP));
            p.cand_value = VALUE_BITS'(nudge(p.ref_value, vspan, VALUE_TOP));
         end
      endcase
      return p;
   endfunction

   function automatic logic [REG_BITS-1:0] random_bandwidth();
      return REG_BITS'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 23));
   endfunction

   task automatic queue_pair(int unsigned rx, int unsigned ry, int unsigned rv,
                             int unsigned cx, int unsigned cy, int unsigned cv);
      pixel_pair_type p;
      p.ref_x      = COORD_BITS'(rx);
      p.ref_y      = COORD_BITS'(ry);
      p.ref_value  = VALUE_BITS'(rv);
      p.cand_x     = COORD_BITS'(cx);
      p.cand_y     = COORD_BITS'(cy);
      p.cand_value = VALUE_BITS'(cv);
      pending_pairs.push_back(p);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [REG_BITS-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_LOC_INV_SQ) loc_bw = data;
      else if (index == CSR_VAL_INV_SQ) val_bw = data;
      csr_writes++;
   endtask

   // block idle: nothing queued, offered or outstanding, pipeline flushed
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_valid || weights_due.size() != 0);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic report_mismatch(string what);
      if (mismatch_count < 20) $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            weights_due.push_back(predict_weight(offered, loc_bw, val_bw));
            pairs_accepted++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pairs.size() != 0) begin
               offered = pending_pairs.pop_front();
               req_ref_x      <= offered.ref_x;
               req_ref_y      <= offered.ref_y;
               req_ref_value  <= offered.ref_value;
               req_cand_x     <= offered.cand_x;
               req_cand_y     <= offered.cand_y;
               req_cand_value <= offered.cand_value;
               offer = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_valid <= offer;
         end
      end
   end

   // receiver stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      bit hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         choke_left = 0;
         mode_left  = 0;
      end else begin
         beat++;
         if (choke_start && choke_left == 0) begin
            choke_left = CHOKE_CYCLES;
            chokes_done++;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left--;
         end
         if (choke_left > 0) begin
            choke_left--;
            hold = 1'b1;
         end else begin
            case (stall_mode)
               0:       hold = 1'b0;
               1:       hold = ($urandom_range(0, 3) == 0);
               2:       hold = (beat % 3 == 0);
               default: hold = ($urandom_range(0, 9) < 7);
            endcase
         end
         rsp_stall <= hold;
      end
   end

   // monitor: compare each weight with the oldest prediction
   always @(posedge clock) begin
      logic [WEIGHT_BITS-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (weights_due.size() == 0) begin
            report_mismatch($sformatf("weight %0d with no transaction outstanding",
                                      rsp_weight));
         end else begin
            want = weights_due.pop_front();
            weights_checked++;
            if (want == 0) zero_count++;
            if (want == 17'd65536) unity_count++;
            if (rsp_weight !== want)
               report_mismatch($sformatf("weight %0d, predicted %0d (transaction %0d)",
                                         rsp_weight, want, weights_checked));
         end
      end
   end

   // stimulus
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset bandwidths: identity, extremes, cut-off borders, operand order
      queue_pair(0, 0, 0, 0, 0, 0);
      queue_pair(COORD_TOP, COORD_TOP, VALUE_TOP, COORD_TOP, COORD_TOP, VALUE_TOP);
      queue_pair(0, 0, 0, COORD_TOP, COORD_TOP, VALUE_TOP);
      queue_pair(COORD_TOP, 0, 0, 0, COORD_TOP, 0);
      queue_pair(10, 20, 0, 10, 20, 80);
      queue_pair(10, 20, 81, 10, 20, 0);
      queue_pair(100, 200, 50, 259, 200, 50);
      queue_pair(260, 200, 50, 100, 200, 50);
      queue_pair(5, 5, 128, 6, 5, 128);
      queue_pair(2000, 1000, 30, 1990, 1010, 37);
      queue_pair(1990, 1010, 37, 2000, 1000, 30);
      wait_drained();

      // spatial step of exactly 1/16, intensity term removed
      write_csr(CSR_LOC_INV_SQ, 24'h100000);
      write_csr(CSR_VAL_INV_SQ, '0);
      @(negedge clock);
      queue_pair(0, 0, 0, 1, 0, VALUE_TOP);
      queue_pair(15, 0, 0, 0, 0, 0);
      queue_pair(0, 0, 0, 0, 16, 0);
      queue_pair(0, 11, 9, 0, 0, 200);
      queue_pair(COORD_TOP, COORD_TOP, 0, COORD_TOP, COORD_TOP, VALUE_TOP);
      wait_drained();

      // both terms removed, then writes to unused indexes
      write_csr(CSR_LOC_INV_SQ, '0);
      write_csr(CSR_VAL_INV_SQ, '0);
      write_csr(CSR_SPARE_2, REG_BITS'($urandom));
      write_csr(CSR_SPARE_3, REG_BITS'($urandom));
      @(negedge clock);
      queue_pair(0, 0, 0, COORD_TOP, COORD_TOP, VALUE_TOP);
      queue_pair(COORD_TOP, 0, VALUE_TOP, 0, COORD_TOP, 0);
      wait_drained();

      // widest bandwidth registers
      write_csr(CSR_LOC_INV_SQ, 24'hFFFFFF);
      write_csr(CSR_VAL_INV_SQ, 24'hFFFFFF);
      @(negedge clock);
      queue_pair(0, 0, 0, 0, 0, 1);
      queue_pair(0, 0, 0, 3, 2, 1);
      queue_pair(0, 0, 0, 4, 0, 0);
      queue_pair(0, 0, 0, 3, 3, 0);
      queue_pair(17, 17, 17, 17, 17, 17);
      wait_drained();

      // random pairs over a range of bandwidth settings
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_LOC_INV_SQ, LOC_INV_SQ_RESET);
               write_csr(CSR_VAL_INV_SQ, VAL_INV_SQ_RESET);
            end
            1: begin
               write_csr(CSR_LOC_INV_SQ, 24'd1);
               write_csr(CSR_VAL_INV_SQ, 24'd1);
            end
            2: begin
               write_csr(CSR_LOC_INV_SQ, 24'hFFFFFF);
               write_csr(CSR_VAL_INV_SQ, 24'hFFFFFF);
            end
            3: begin
               write_csr(CSR_LOC_INV_SQ, '0);
               write_csr(CSR_VAL_INV_SQ, random_bandwidth());
            end
            4: begin
               write_csr(CSR_LOC_INV_SQ, random_bandwidth());
               write_csr(CSR_VAL_INV_SQ, '0);
            end
            default: begin
               write_csr(CSR_LOC_INV_SQ, random_bandwidth());
               write_csr(CSR_VAL_INV_SQ, random_bandwidth());
            end
         endcase
         write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, REG_BITS'($urandom));
         @(negedge clock);
         for (int n = 0; n < RANDOM_PAIRS / PHASES; n++)
            pending_pairs.push_back(random_pair());
         // hold the receiver off while the sender keeps offering
         if (ph == 5) begin
            @(posedge clock);
            choke_start <= 1'b1;
            @(posedge clock);
            choke_start <= 1'b0;
         end
         wait_drained();
      end

      if (weights_due.size() != 0)
         report_mismatch($sformatf("%0d weights never returned", weights_due.size()));
      $display("Checked %0d of %0d pixel pairs over %0d register writes, %0d long hold-off(s).",
               weights_checked, pairs_accepted, csr_writes, chokes_done);
      $display("Weights seen: %0d at unity, %0d cut to zero, %0d in between.",
               unity_count, zero_count, weights_checked - unity_count - zero_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("Timed out with %0d weights outstanding.", weights_due.size());
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/baw_pkg.sv
rtl/baw_exp_unit.sv
rtl/bilateral_affinity_weight.sv
sim/tb.sv
